>>> rtl/srmw_pkg.sv
// Shared types, constants and helper functions of the spectral whitener.
// Used by every module in the rtl folder but srmw_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srmw_pkg;

    // Fixed field widths of the stream items.
    localparam int SAMPLE_WIDTH = 24;
    localparam int MAX_BINS     = 4096;
    localparam int CNT_W        = 13;
    localparam int IDX_W        = 12;
    localparam int CFG_W        = 13;
    localparam int HALF_W       = 6;
    localparam int CFG_ADDR_W   = 2;

    // Arithmetic widths.
    localparam int MAG_W     = 24;
    localparam int SQ_W      = 2 * SAMPLE_WIDTH;
    localparam int SUM_W     = 31;
    localparam int WIN_W     = 7;
    localparam int PROD_W    = 31;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = SUM_W + 1;
    localparam int QUO_W     = 24;
    localparam int FRAC_BITS = 15;

    // Stream widths.
    localparam int S_DATA_W = 2 * SAMPLE_WIDTH;
    localparam int M_DATA_W = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_BIN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_END_BIN    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_WIDTH = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_WRITE,
        ST_CHECK,
        ST_SETUP,
        ST_SAMP,
        ST_SUM,
        ST_MUL_RE,
        ST_DGO_RE,
        ST_DWAIT_RE,
        ST_MUL_IM,
        ST_DGO_IM,
        ST_DWAIT_IM,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // Status of the divider as seen by the sequencer.
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_stat_t;

    // Apply the sign and saturate a rounded quotient to signed Q8.15.
    function automatic logic [SAMPLE_WIDTH-1:0] saturate_part(
        input logic             neg,
        input logic             ovf,
        input logic [QUO_W-1:0] q
    );
        logic [SAMPLE_WIDTH-1:0] res;
        if (neg) begin
            if (ovf || q > QUO_W'(24'h800000)) begin
                res = 24'h800000;
            end else begin
                res = ~q + 24'd1;
            end
        end else begin
            if (ovf || q > QUO_W'(24'h7FFFFF)) begin
                res = 24'h7FFFFF;
            end else begin
                res = q;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/srmw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the sample and magnitude delay lines.
`timescale 1ns / 1ps
`default_nettype none

module srmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/srmw_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on srmw_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module srmw_sqrt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [srmw_pkg::SQ_W-1:0]   radicand,
    output      logic                        done,
    output      logic [srmw_pkg::MAG_W-1:0]  root
);
    import srmw_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic [SQ_W-1:0]    op_reg;
    logic [MAG_W+1:0]   rem_reg;
    logic [MAG_W-1:0]   root_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [MAG_W+3:0]   rem_sh;
    logic [MAG_W+3:0]   trial;
    logic               take;

    // One digit of the root: bring down two bits and try the next odd term.
    always_comb begin
        rem_sh = {rem_reg, op_reg[SQ_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        take   = (rem_sh >= trial);
    end

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath of the iteration.
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= STEP_W'(MAG_W - 1);
        end else if (busy_reg) begin
            op_reg   <= {op_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= take ? (MAG_W+2)'(rem_sh - trial) : rem_sh[MAG_W+1:0];
            root_reg <= {root_reg[MAG_W-2:0], take};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> rtl/srmw_div.sv
// Iterative restoring divider, one quotient bit per cycle, with overflow check.
// Depends on srmw_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module srmw_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [srmw_pkg::NUM_W-1:0]  num,
    input  wire logic [srmw_pkg::DEN_W-1:0]  den,
    output      srmw_pkg::div_stat_t         stat
);
    import srmw_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);
    localparam int WIDE_W = DEN_W + QUO_W;

    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              ovf_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    rem_sh;
    logic              take;

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
        rem_sh = {rem_reg, low_reg[QUO_W-1]};
        take   = (rem_sh >= {1'b0, den_reg});
    end

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: the quotient overflows when num reaches den times 2^QUO_W.
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg  <= den;
            rem_reg  <= DEN_W'(num[NUM_W-1:QUO_W]);
            low_reg  <= num[QUO_W-1:0];
            quo_reg  <= '0;
            ovf_reg  <= (WIDE_W'(num) >= {den, {QUO_W{1'b0}}});
            step_reg <= STEP_W'(QUO_W - 1);
        end else if (busy_reg) begin
            rem_reg  <= take ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            low_reg  <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[QUO_W-2:0], take};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign stat.quo  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/spectral_running_mean_whitener_unit.sv
// Top level of the running-mean spectral whitener: sequencer, shared multiplier,
// delay-line RAMs. Depends on srmw_pkg, srmw_ram, srmw_sqrt and srmw_div.
//
//  Channel   | Direction | Handshake         | Payload
//  s_        | in        | s_tvalid/s_tready | s_tdata: re_in, im_in
//  m_        | out       | m_tvalid/m_tready | m_tdata: re_out, im_out, bin_index;
//            |           |                   | m_tlast: last_bin; m_tuser: zero_mean
//  cfg_      | in        | cfg_we            | cfg_addr, cfg_wdata
//
// When a bin releases no result, the time from one accepted request to the next
// is set mostly by the 24-step square root. Each result in the band adds the two
// 24-step divisions and the window length (up to 2*half_width+1 magnitude reads,
// one per cycle, through the single magnitude RAM read port). s_tready is high
// only while the sequencer is idle. A stalled m_ channel holds the next result in
// the sequencer until the output register frees. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module spectral_running_mean_whitener_unit #(
    parameter int MAX_HALF = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // re_in [23:0], im_in [47:24]
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [srmw_pkg::S_DATA_W-1:0]     s_tdata,
    // re_out [23:0], im_out [47:24], bin_index [59:48], zero fill [63:60]
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [srmw_pkg::M_DATA_W-1:0]     m_tdata,
    output      logic                              m_tlast,
    // zero_mean [0]
    output      logic [0:0]                        m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [srmw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [srmw_pkg::CFG_W-1:0]        cfg_wdata
);
    import srmw_pkg::*;

    localparam int SDEPTH = MAX_HALF + 1;
    localparam int MDEPTH = 2 * MAX_HALF + 1;
    localparam int SPTR_W = $clog2(SDEPTH);
    localparam int MPTR_W = $clog2(MDEPTH);

    // Configuration registers and the copy latched at bin 0.
    logic [CNT_W-1:0]  cfg_n_reg;
    logic [IDX_W-1:0]  cfg_first_reg;
    logic [CNT_W-1:0]  cfg_end_reg;
    logic [HALF_W-1:0] cfg_half_reg;
    logic [CNT_W-1:0]  lat_n_reg;
    logic [IDX_W-1:0]  lat_first_reg;
    logic [CNT_W-1:0]  lat_end_reg;
    logic [HALF_W-1:0] lat_half_reg;

    // Sequencer and counters.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [SPTR_W-1:0] sptr_k_reg;
    logic [MPTR_W-1:0] mptr_k_reg;

    // Datapath registers.
    logic [SAMPLE_WIDTH-1:0] re_reg, im_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [CNT_W-1:0]        hi_reg, j_reg;
    logic [MPTR_W-1:0]       jptr_reg;
    logic                    band_reg;
    logic                    pend_reg;
    logic [WIN_W-1:0]        win_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SAMPLE_WIDTH-1:0] sre_reg, sim_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [SAMPLE_WIDTH-1:0] res_re_reg, res_im_reg;
    logic                    zero_reg;

    // Output register.
    logic                    m_valid_reg;
    logic [SAMPLE_WIDTH-1:0] m_re_reg, m_im_reg;
    logic [IDX_W-1:0]        m_idx_reg;
    logic                    m_last_reg, m_zero_reg;

    // Combinational signals.
    logic                    in_req;
    logic                    out_free;
    logic                    last_c;
    logic                    emit_c;
    logic                    sum_issue;
    logic                    sum_done;
    logic [CNT_W-1:0]        n_c, h_c, end_c, hmax_c;
    logic [CNT_W-1:0]        half_ext;
    logic [CNT_W-1:0]        bm_c, lo_c, bp_c, hi_c;
    logic [SPTR_W:0]         sdist_c, sptr_b_c;
    logic [MPTR_W:0]         mdist_c, mptr_lo_c;
    logic [SAMPLE_WIDTH-1:0] mul_a, mul_b;
    logic [SQ_W-1:0]         mul_p;
    logic [SAMPLE_WIDTH-1:0] abs_re, abs_im, abs_sre, abs_sim;
    logic                    sqrt_start, sqrt_done;
    logic [MAG_W-1:0]        sqrt_root;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    div_stat_t               dstat;
    logic                    ram_we;
    logic                    s_rd_en, m_rd_en;
    logic [S_DATA_W-1:0]     s_rdata;
    logic [MAG_W-1:0]        m_rdata;

    assign in_req   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign half_ext = CNT_W'(lat_half_reg);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_n_reg     <= CNT_W'(MAX_BINS);
            cfg_first_reg <= '0;
            cfg_end_reg   <= CNT_W'(MAX_BINS);
            cfg_half_reg  <= HALF_W'(8);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BIN_COUNT:  cfg_n_reg     <= cfg_wdata;
                REG_FIRST_BIN:  cfg_first_reg <= cfg_wdata[IDX_W-1:0];
                REG_END_BIN:    cfg_end_reg   <= cfg_wdata;
                REG_HALF_WIDTH: cfg_half_reg  <= cfg_wdata[HALF_W-1:0];
            endcase
        end
    end

    // Clamped settings that take effect at bin 0.
    always_comb begin
        if (cfg_n_reg == '0) begin
            n_c = CNT_W'(1);
        end else if (cfg_n_reg > CNT_W'(MAX_BINS)) begin
            n_c = CNT_W'(MAX_BINS);
        end else begin
            n_c = cfg_n_reg;
        end
        hmax_c = (n_c - CNT_W'(1)) >> 1;
        h_c    = CNT_W'(cfg_half_reg);
        if (h_c > CNT_W'(MAX_HALF)) begin
            h_c = CNT_W'(MAX_HALF);
        end
        if (h_c > hmax_c) begin
            h_c = hmax_c;
        end
        end_c = (cfg_end_reg > n_c) ? n_c : cfg_end_reg;
    end

    // Result release condition and window bounds for the next result bin.
    always_comb begin
        last_c = ({1'b0, k_reg} + (CNT_W+1)'(1)) >= {1'b0, lat_n_reg};
        if (last_c) begin
            emit_c = (out_cnt_reg <= k_reg);
        end else begin
            emit_c = (k_reg >= half_ext) && (out_cnt_reg <= k_reg - half_ext);
        end
        bm_c = (out_cnt_reg >= half_ext) ? out_cnt_reg - half_ext : '0;
        lo_c = (bm_c < CNT_W'(lat_first_reg)) ? CNT_W'(lat_first_reg) : bm_c;
        bp_c = out_cnt_reg + half_ext;
        hi_c = (bp_c > lat_end_reg - CNT_W'(1)) ? lat_end_reg - CNT_W'(1) : bp_c;
        sdist_c = (SPTR_W+1)'(k_reg - out_cnt_reg);
        if ({1'b0, sptr_k_reg} >= sdist_c) begin
            sptr_b_c = {1'b0, sptr_k_reg} - sdist_c;
        end else begin
            sptr_b_c = {1'b0, sptr_k_reg} + (SPTR_W+1)'(SDEPTH) - sdist_c;
        end
        mdist_c = (MPTR_W+1)'(k_reg - lo_c);
        if ({1'b0, mptr_k_reg} >= mdist_c) begin
            mptr_lo_c = {1'b0, mptr_k_reg} - mdist_c;
        end else begin
            mptr_lo_c = {1'b0, mptr_k_reg} + (MPTR_W+1)'(MDEPTH) - mdist_c;
        end
    end

    // Window sum read control.
    assign sum_issue = (j_reg <= hi_reg);
    assign sum_done  = !sum_issue && !pend_reg;

    // Magnitudes of the operands fed to the shared multiplier.
    always_comb begin
        abs_re  = re_reg[SAMPLE_WIDTH-1]  ? ~re_reg + 24'd1  : re_reg;
        abs_im  = im_reg[SAMPLE_WIDTH-1]  ? ~im_reg + 24'd1  : im_reg;
        abs_sre = sre_reg[SAMPLE_WIDTH-1] ? ~sre_reg + 24'd1 : sre_reg;
        abs_sim = sim_reg[SAMPLE_WIDTH-1] ? ~sim_reg + 24'd1 : sim_reg;
    end

    // Shared multiplier: squares of the input, then part times window count.
    always_comb begin
        unique case (state_reg)
            ST_SQ_RE: begin
                mul_a = abs_re;
                mul_b = abs_re;
            end
            ST_SQ_IM: begin
                mul_a = abs_im;
                mul_b = abs_im;
            end
            ST_MUL_IM: begin
                mul_a = abs_sim;
                mul_b = SAMPLE_WIDTH'(win_reg);
            end
            default: begin
                mul_a = abs_sre;
                mul_b = SAMPLE_WIDTH'(win_reg);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Rounded quotient: (2 * part * count * 2^15 + sum) / (2 * sum).
    assign div_num = NUM_W'({prod_reg, 1'b0, {FRAC_BITS{1'b0}}}) + NUM_W'(sum_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_req) state_next = ST_SQ_RE;
            ST_SQ_RE:     state_next = ST_SQ_IM;
            ST_SQ_IM:     state_next = ST_SQRT_GO;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (sqrt_done) state_next = ST_WRITE;
            ST_WRITE:     state_next = ST_CHECK;
            ST_CHECK:     state_next = emit_c ? ST_SETUP : ST_FINISH;
            ST_SETUP:     state_next = ST_SAMP;
            ST_SAMP:      state_next = band_reg ? ST_SUM : ST_EMIT;
            ST_SUM: begin
                if (sum_done) begin
                    state_next = (sum_reg == '0) ? ST_EMIT : ST_MUL_RE;
                end
            end
            ST_MUL_RE:    state_next = ST_DGO_RE;
            ST_DGO_RE:    state_next = ST_DWAIT_RE;
            ST_DWAIT_RE:  if (dstat.done) state_next = ST_MUL_IM;
            ST_MUL_IM:    state_next = ST_DGO_IM;
            ST_DGO_IM:    state_next = ST_DWAIT_IM;
            ST_DWAIT_IM:  if (dstat.done) state_next = ST_EMIT;
            ST_EMIT:      if (out_free) state_next = ST_CHECK;
            ST_FINISH:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        sqrt_start = (state_reg == ST_SQRT_GO);
        div_start  = (state_reg == ST_DGO_RE) || (state_reg == ST_DGO_IM);
        ram_we     = (state_reg == ST_WRITE);
        s_rd_en    = (state_reg == ST_SETUP);
        m_rd_en    = (state_reg == ST_SUM) && sum_issue;
    end

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            out_cnt_reg <= '0;
            sptr_k_reg  <= '0;
            mptr_k_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free) begin
                out_cnt_reg <= out_cnt_reg + CNT_W'(1);
            end
            if (state_reg == ST_FINISH) begin
                if (last_c) begin
                    k_reg       <= '0;
                    out_cnt_reg <= '0;
                    sptr_k_reg  <= '0;
                    mptr_k_reg  <= '0;
                end else begin
                    k_reg      <= k_reg + CNT_W'(1);
                    sptr_k_reg <= (sptr_k_reg == SPTR_W'(SDEPTH - 1)) ? '0
                                  : sptr_k_reg + SPTR_W'(1);
                    mptr_k_reg <= (mptr_k_reg == MPTR_W'(MDEPTH - 1)) ? '0
                                  : mptr_k_reg + MPTR_W'(1);
                end
            end
        end
    end

    // Input capture, settings latch and magnitude square.
    always_ff @(posedge aclk) begin
        if (in_req) begin
            re_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            im_reg <= s_tdata[S_DATA_W-1:SAMPLE_WIDTH];
            if (k_reg == '0) begin
                lat_n_reg     <= n_c;
                lat_first_reg <= cfg_first_reg;
                lat_end_reg   <= end_c;
                lat_half_reg  <= h_c[HALF_W-1:0];
            end
        end
        if (state_reg == ST_SQ_RE) begin
            sq_reg <= mul_p;
        end
        if (state_reg == ST_SQ_IM) begin
            sq_reg <= sq_reg + mul_p;
        end
    end

    // Window setup, sum accumulation and scaling.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_SETUP: begin
                band_reg <= (out_cnt_reg >= CNT_W'(lat_first_reg))
                            && (out_cnt_reg < lat_end_reg);
                hi_reg   <= hi_c;
                j_reg    <= lo_c;
                jptr_reg <= mptr_lo_c[MPTR_W-1:0];
                win_reg  <= WIN_W'(hi_c - lo_c + CNT_W'(1));
                sum_reg  <= '0;
                pend_reg <= 1'b0;
            end
            ST_SAMP: begin
                sre_reg    <= s_rdata[SAMPLE_WIDTH-1:0];
                sim_reg    <= s_rdata[S_DATA_W-1:SAMPLE_WIDTH];
                res_re_reg <= s_rdata[SAMPLE_WIDTH-1:0];
                res_im_reg <= s_rdata[S_DATA_W-1:SAMPLE_WIDTH];
                zero_reg   <= 1'b0;
            end
            ST_SUM: begin
                pend_reg <= sum_issue;
                if (sum_issue) begin
                    j_reg    <= j_reg + CNT_W'(1);
                    jptr_reg <= (jptr_reg == MPTR_W'(MDEPTH - 1)) ? '0
                                : jptr_reg + MPTR_W'(1);
                end
                if (pend_reg) begin
                    sum_reg <= sum_reg + SUM_W'(m_rdata);
                end
                if (sum_done && sum_reg == '0) begin
                    res_re_reg <= '0;
                    res_im_reg <= '0;
                    zero_reg   <= 1'b1;
                end
            end
            ST_MUL_RE, ST_MUL_IM: begin
                prod_reg <= mul_p[PROD_W-1:0];
            end
            ST_DWAIT_RE: begin
                if (dstat.done) begin
                    res_re_reg <= saturate_part(sre_reg[SAMPLE_WIDTH-1], dstat.ovf, dstat.quo);
                end
            end
            ST_DWAIT_IM: begin
                if (dstat.done) begin
                    res_im_reg <= saturate_part(sim_reg[SAMPLE_WIDTH-1], dstat.ovf, dstat.quo);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_re_reg   <= res_re_reg;
            m_im_reg   <= res_im_reg;
            m_idx_reg  <= out_cnt_reg[IDX_W-1:0];
            m_last_reg <= last_c && (out_cnt_reg == k_reg);
            m_zero_reg <= zero_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {{(M_DATA_W - S_DATA_W - IDX_W){1'b0}}, m_idx_reg, m_im_reg, m_re_reg};
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_zero_reg;

    // Delay line of complex samples.
    srmw_ram #(
        .WIDTH (S_DATA_W),
        .DEPTH (SDEPTH)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (sptr_k_reg),
        .wdata ({im_reg, re_reg}),
        .re    (s_rd_en),
        .raddr (sptr_b_c[SPTR_W-1:0]),
        .rdata (s_rdata)
    );

    // Delay line of magnitudes.
    srmw_ram #(
        .WIDTH (MAG_W),
        .DEPTH (MDEPTH)
    ) u_mag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (mptr_k_reg),
        .wdata (sqrt_root),
        .re    (m_rd_en),
        .raddr (jptr_reg),
        .rdata (m_rdata)
    );

    srmw_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    srmw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     ({sum_reg, 1'b0}),
        .stat    (dstat)
    );

    // Results never run more than one bin ahead of the input count.
    a_out_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, out_cnt_reg} <= {1'b0, k_reg} + (CNT_W+1)'(1)))
        else $error("result counter ran ahead of input counter");

    // A pending result is never further back than the window half width.
    a_delay_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && out_cnt_reg <= k_reg)
        |-> ((k_reg - out_cnt_reg) <= half_ext))
        else $error("pending result older than the delay line");

    // An accepted request closes the input until its work is done.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after a request");

    // Divider results arrive only while the sequencer waits for them.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        dstat.done |-> (state_reg == ST_DWAIT_RE || state_reg == ST_DWAIT_IM))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for the running-mean spectral whitener unit.
// Depends on srmw_pkg and spectral_running_mean_whitener_unit from the rtl folder.
`timescale 1ns / 1ps

module testbench;
    import srmw_pkg::*;

    localparam int HOLD_DEPTH = 33;
    localparam int MAG_DEPTH  = 65;
    localparam int SETTLE     = 64;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [23:0] re;
        logic [23:0] im;
        logic [11:0] bin;
        logic        last;
        logic        zero;
    } whitened_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    // Predictor state.
    logic signed [23:0] held_re [HOLD_DEPTH];
    logic signed [23:0] held_im [HOLD_DEPTH];
    longint unsigned    mag_hist [MAG_DEPTH];
    int unsigned        in_bin;
    int unsigned        out_bin;
    int unsigned        reg_count, reg_first, reg_end, reg_half;
    int unsigned        act_count, act_first, act_end, act_half;

    whitened_t   expected_bins[$];
    int          errors;
    int          items_sent;
    bit          no_idle;
    int          quiet_cycles = 0;

    spectral_running_mean_whitener_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale one part by count/sum in Q8.15, round half away from zero, saturate.
    function automatic logic [23:0] whiten_part(longint x, longint unsigned cnt,
                                                longint unsigned sum);
        longint unsigned ax;
        longint unsigned num;
        longint unsigned q;
        ax = (x < 0) ? longint'(-x) : longint'(x);
        num = (ax * cnt) << 15;
        q = (2 * num + sum) / (2 * sum);
        if (x < 0) begin
            if (q > 64'h800000) q = 64'h800000;
            return 24'(-q);
        end
        if (q > 64'h7FFFFF) q = 64'h7FFFFF;
        return 24'(q);
    endfunction

    // Register values only take effect at bin 0 of a spectrum.
    function automatic void latch_settings();
        int unsigned n;
        int unsigned h;
        n = reg_count;
        h = reg_half;
        if (n < 1) n = 1;
        if (n > MAX_BINS) n = MAX_BINS;
        if (h > 32) h = 32;
        if (h > (n - 1) / 2) h = (n - 1) / 2;
        act_count = n;
        act_half  = h;
        act_first = reg_first;
        act_end   = (reg_end > n) ? n : reg_end;
    endfunction

    // Work out every result released by one accepted bin.
    function automatic void predict_whitened(logic signed [23:0] re, logic signed [23:0] im);
        int unsigned     k;
        int unsigned     b;
        int unsigned     lo;
        int unsigned     hi;
        longint unsigned sum;
        longint          ar;
        longint          ai;
        bit              last;
        int              released;
        whitened_t       w;
        k = in_bin;
        if (k == 0) latch_settings();
        held_re[k % HOLD_DEPTH] = re;
        held_im[k % HOLD_DEPTH] = im;
        ar = re;
        ai = im;
        if (ar < 0) ar = -ar;
        if (ai < 0) ai = -ai;
        mag_hist[k % MAG_DEPTH] = int_sqrt(ar * ar + ai * ai);
        last = (k + 1 >= act_count);
        released = 0;
        while (released <= 32 && (last ? out_bin <= k
                : (k >= act_half && out_bin <= k - act_half))) begin
            b = out_bin;
            w.re   = held_re[b % HOLD_DEPTH];
            w.im   = held_im[b % HOLD_DEPTH];
            w.zero = 1'b0;
            if (b >= act_first && b < act_end) begin
                lo = (b >= act_half) ? b - act_half : 0;
                hi = b + act_half;
                if (lo < act_first) lo = act_first;
                if (hi > act_end - 1) hi = act_end - 1;
                sum = 0;
                for (int unsigned j = lo; j <= hi; j++) sum += mag_hist[j % MAG_DEPTH];
                if (sum == 0) begin
                    w.re   = '0;
                    w.im   = '0;
                    w.zero = 1'b1;
                end else begin
                    w.re = whiten_part(held_re[b % HOLD_DEPTH], hi - lo + 1, sum);
                    w.im = whiten_part(held_im[b % HOLD_DEPTH], hi - lo + 1, sum);
                end
            end
            w.bin  = 12'(b);
            w.last = last && (b == k);
            expected_bins.push_back(w);
            released++;
            out_bin = (b + 1) & 13'h1FFF;
        end
        if (last) begin
            in_bin  = 0;
            out_bin = 0;
        end else begin
            in_bin = (k + 1) & 13'h1FFF;
        end
    endfunction

    // Send one bin request and update the prediction once it is accepted.
    task automatic send_bin(logic signed [23:0] re, logic signed [23:0] im);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {im, re};
        do @(posedge aclk); while (!s_tready);
        predict_whitened(re, im);
        items_sent++;
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Wait until the unit has drained, then write one register.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned value);
        wait_drained();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = CFG_W'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_BIN_COUNT:  reg_count = value & 13'h1FFF;
            REG_FIRST_BIN:  reg_first = value & 12'hFFF;
            REG_END_BIN:    reg_end   = value & 13'h1FFF;
            REG_HALF_WIDTH: reg_half  = value & 6'h3F;
            default: ;
        endcase
    endtask

    task automatic set_band(int unsigned n, int unsigned first, int unsigned last_end,
                            int unsigned half);
        write_reg(REG_BIN_COUNT, n);
        write_reg(REG_FIRST_BIN, first);
        write_reg(REG_END_BIN, last_end);
        write_reg(REG_HALF_WIDTH, half);
    endtask

    // Sample value: full range, small values or zero.
    function automatic logic signed [23:0] draw_part(int flavor);
        case (flavor)
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 400)) - 24'sd200;
            default: return '0;
        endcase
    endfunction

    task automatic send_spectrum(int unsigned n, int flavor);
        int f;
        for (int unsigned i = 0; i < n; i++) begin
            f = (flavor < 0) ? $urandom_range(0, 2) : flavor;
            send_bin(draw_part(f), draw_part(f));
        end
    endtask

    // Corner values of the samples, clamping and empty or partial bands.
    task automatic test_directed();
        set_band(0, 0, 8191, 63);
        send_bin(-24'sd8388608, -24'sd8388608);
        set_band(8, 0, 8191, 63);
        send_bin(24'sd8388607, 24'sd8388607);
        send_bin(-24'sd8388608, 24'sd8388607);
        send_bin(24'sd0, 24'sd0);
        send_bin(24'sd1, -24'sd1);
        send_bin(24'sd8388607, -24'sd8388608);
        send_bin(-24'sd1, 24'sd0);
        send_bin(24'sd100, 24'sd3);
        send_bin(24'sd0, -24'sd7);
        // All-zero spectrum gives zero windows everywhere.
        send_spectrum(8, 2);
        // Band inside the spectrum, and then an empty band.
        set_band(8, 2, 5, 1);
        send_spectrum(8, 1);
        set_band(5, 4095, 0, 0);
        send_spectrum(5, 0);
    endtask

    // Random settings, each used for one to three spectra.
    task automatic test_random_spectra();
        int unsigned n;
        while (items_sent < 90) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 70) : $urandom_range(1, 20);
            set_band(n, $urandom_range(0, n + 2), $urandom_range(0, n + 3),
                     $urandom_range(0, 63));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) send_spectrum((n == 0) ? 1 : n, -1);
            no_idle = 1'b0;
        end
    endtask

    // Widest window: an oversized half width is clamped to the maximum.
    task automatic test_wide_window();
        set_band(70, 0, 8191, 63);
        no_idle = 1'b1;
        send_spectrum(70, -1);
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, then compare against the oldest prediction.
    initial begin
        whitened_t w;
        int        stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_bins.size() == 0) begin
                $error("unexpected result for bin %0d", m_tdata[59:48]);
                errors++;
            end else begin
                w = expected_bins.pop_front();
                if (m_tdata[23:0] !== w.re) begin
                    $error("re_out: expected %h, got %h", w.re, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[47:24] !== w.im) begin
                    $error("im_out: expected %h, got %h", w.im, m_tdata[47:24]);
                    errors++;
                end
                if (m_tdata[59:48] !== w.bin) begin
                    $error("bin_index: expected %0d, got %0d", w.bin, m_tdata[59:48]);
                    errors++;
                end
                if (m_tlast !== w.last) begin
                    $error("last_bin: expected %b, got %b", w.last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== w.zero) begin
                    $error("zero_mean: expected %b, got %b", w.zero, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request, accepted result or register write.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        errors       = 0;
        items_sent   = 0;
        no_idle      = 1'b0;
        in_bin       = 0;
        out_bin      = 0;
        reg_count    = 4096;
        reg_first    = 0;
        reg_end      = 4096;
        reg_half     = 8;
        latch_settings();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_BIN_COUNT;
        cfg_wdata = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_spectra();
        test_wide_window();
        wait_drained();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/srmw_pkg.sv
rtl/srmw_ram.sv
rtl/srmw_sqrt.sv
rtl/srmw_div.sv
rtl/spectral_running_mean_whitener_unit.sv
tb/sv/testbench.sv
